FILE: src/bspa_pkg.sv
// ----------------------------------------------------------------------------
// bspa_pkg
// Shared sizes, request codes and the patch record layout for the
// byte stream patch applier.
// ----------------------------------------------------------------------------
package bspa_pkg;

  localparam int MAX_RECORDS  = 64;
  localparam int REC_AW       = $clog2(MAX_RECORDS);
  localparam int REC_CW       = $clog2(MAX_RECORDS + 1);
  localparam int INSERT_STORE = 1024;
  localparam int INS_AW       = $clog2(INSERT_STORE);
  localparam int INS_CW       = $clog2(INSERT_STORE + 1);
  localparam int MAX_INSERT   = 63;
  localparam int LEN_BITS     = 8;
  localparam int BYTE_BITS    = 8;
  localparam int OFFSET_BITS  = 32;
  localparam int RESULT_LIMIT = 64;
  localparam int RES_CW       = $clog2(RESULT_LIMIT + 1);

  localparam logic [1:0] REQ_LOAD_REC  = 2'd0;
  localparam logic [1:0] REQ_LOAD_BYTE = 2'd1;
  localparam logic [1:0] REQ_STREAM    = 2'd2;
  localparam logic [1:0] REQ_CLEAR     = 2'd3;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic                   is_insert;
    logic [LEN_BITS-1:0]    len;
    logic [INS_AW-1:0]      start;
  } rec_t;

endpackage

FILE: src/byte_stream_patch_applier.sv
// ----------------------------------------------------------------------------
// byte_stream_patch_applier
// Load, clear and skipped stream items are taken in ST_IDLE, which they do not leave.
// Other stream bytes pass through ST_CHECK, with a visit to ST_INS for each matched
// insert record that holds bytes, and end in ST_FIN; both RAM reads are registered.
// Matched records delay the results of a byte, and output stalls hold the block;
// one item at a time.
// Synchronous reset empties the table; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module byte_stream_patch_applier (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       req_type,
  input  logic [bspa_pkg::OFFSET_BITS-1:0] rec_offset,
  input  logic                             rec_is_insert,
  input  logic [bspa_pkg::LEN_BITS-1:0]    del_count,
  input  logic [bspa_pkg::BYTE_BITS-1:0]   byte_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bspa_pkg::BYTE_BITS-1:0]   out_byte,
  output logic                             last_of_run
);

  import bspa_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_INS   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]             state;
  logic [REC_CW-1:0]      record_count;
  logic [REC_CW-1:0]      next_record;
  logic [INS_CW-1:0]      insert_fill;
  logic [OFFSET_BITS-1:0] stream_offset;
  logic [LEN_BITS-1:0]    skip_left;

  logic [OFFSET_BITS-1:0] last_offset;
  logic                   last_kind;
  logic [LEN_BITS-1:0]    last_len;
  logic [INS_AW-1:0]      last_start;

  logic [BYTE_BITS-1:0]   cur_byte;
  logic [RES_CW-1:0]      res_cnt;
  logic                   pend_valid;
  logic [BYTE_BITS-1:0]   pend_byte;
  logic [LEN_BITS-1:0]    ins_left;
  logic [INS_AW-1:0]      ins_addr;

  logic                   rec_we;
  logic [REC_AW-1:0]      rec_waddr;
  rec_t                   rec_wdata;
  logic                   rec_re;
  logic [REC_AW-1:0]      rec_raddr;
  rec_t                   rec_rdata;
  logic                   ins_we;
  logic                   ins_re;
  logic [INS_AW-1:0]      ins_raddr;
  logic [BYTE_BITS-1:0]   ins_rdata;

  logic                   in_fire;
  logic                   out_free;
  logic                   out_load;
  logic                   load_ok;
  logic                   byte_ok;
  logic [REC_CW-1:0]      rec_last_idx;
  logic [REC_CW-1:0]      next_record_inc;
  logic                   rec_match;
  logic                   gen_block;
  logic                   gen_fire;
  logic [BYTE_BITS-1:0]   gen_value;

  bspa_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(MAX_RECORDS)
  ) u_rec_ram (
    .clk  (clk),
    .we   (rec_we),
    .waddr(rec_waddr),
    .wdata(rec_wdata),
    .re   (rec_re),
    .raddr(rec_raddr),
    .rdata(rec_rdata)
  );

  bspa_ram #(
    .WIDTH(BYTE_BITS),
    .DEPTH(INSERT_STORE)
  ) u_ins_ram (
    .clk  (clk),
    .we   (ins_we),
    .waddr(insert_fill[INS_AW-1:0]),
    .wdata(byte_value),
    .re   (ins_re),
    .raddr(ins_raddr),
    .rdata(ins_rdata)
  );

  assign in_ready        = (state == ST_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign out_free        = !out_valid || out_ready;
  assign load_ok         = record_count < REC_CW'(MAX_RECORDS);
  assign byte_ok         = (record_count != '0) && last_kind &&
                           (last_len < LEN_BITS'(MAX_INSERT)) &&
                           (insert_fill < INS_CW'(INSERT_STORE));
  assign rec_last_idx    = record_count - REC_CW'(1);
  assign next_record_inc = next_record + REC_CW'(1);
  assign rec_match       = (next_record < record_count) &&
                           (rec_rdata.offset == stream_offset);
  assign gen_block       = pend_valid && !out_free && (res_cnt < RES_CW'(RESULT_LIMIT));
  assign out_load        = (state == ST_FIN && pend_valid && out_free) ||
                           (gen_fire && pend_valid && (res_cnt < RES_CW'(RESULT_LIMIT)));

  always_comb begin
    gen_fire  = 1'b0;
    gen_value = cur_byte;
    if (state == ST_CHECK && !rec_match && !gen_block) begin
      gen_fire = 1'b1;
    end else if (state == ST_INS && !gen_block) begin
      gen_fire  = 1'b1;
      gen_value = ins_rdata;
    end
  end

  always_comb begin
    rec_we          = 1'b0;
    rec_waddr       = record_count[REC_AW-1:0];
    rec_wdata       = '0;
    rec_wdata.offset    = rec_offset;
    rec_wdata.is_insert = rec_is_insert;
    rec_wdata.len       = rec_is_insert ? '0 : del_count;
    rec_wdata.start     = insert_fill[INS_AW-1:0];
    rec_re          = 1'b0;
    rec_raddr       = next_record[REC_AW-1:0];
    ins_we          = 1'b0;
    ins_re          = 1'b0;
    ins_raddr       = ins_addr + INS_AW'(1);
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (req_type)
            REQ_LOAD_REC: begin
              rec_we = load_ok;
            end
            REQ_LOAD_BYTE: begin
              if (byte_ok) begin
                ins_we              = 1'b1;
                rec_we              = 1'b1;
                rec_waddr           = rec_last_idx[REC_AW-1:0];
                rec_wdata.offset    = last_offset;
                rec_wdata.is_insert = 1'b1;
                rec_wdata.len       = last_len + LEN_BITS'(1);
                rec_wdata.start     = last_start;
              end
            end
            REQ_STREAM: begin
              rec_re = (skip_left == '0);
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (rec_match) begin
          if (rec_rdata.is_insert && rec_rdata.len != '0) begin
            ins_re    = 1'b1;
            ins_raddr = rec_rdata.start;
          end else if (rec_rdata.is_insert || rec_rdata.len == '0) begin
            rec_re    = 1'b1;
            rec_raddr = next_record_inc[REC_AW-1:0];
          end
        end
      end
      ST_INS: begin
        if (!gen_block) begin
          if (ins_left == LEN_BITS'(1)) begin
            rec_re = 1'b1;
          end else begin
            ins_re = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      record_count  <= '0;
      next_record   <= '0;
      insert_fill   <= '0;
      stream_offset <= '0;
      skip_left     <= '0;
      last_kind     <= 1'b0;
      last_len      <= '0;
      res_cnt       <= '0;
      pend_valid    <= 1'b0;
      ins_left      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (req_type)
              REQ_LOAD_REC: begin
                if (load_ok) begin
                  record_count <= record_count + REC_CW'(1);
                  last_offset  <= rec_offset;
                  last_kind    <= rec_is_insert;
                  last_len     <= rec_is_insert ? '0 : del_count;
                  last_start   <= insert_fill[INS_AW-1:0];
                end
              end
              REQ_LOAD_BYTE: begin
                if (byte_ok) begin
                  insert_fill <= insert_fill + INS_CW'(1);
                  last_len    <= last_len + LEN_BITS'(1);
                end
              end
              REQ_STREAM: begin
                if (skip_left != '0) begin
                  skip_left     <= skip_left - LEN_BITS'(1);
                  stream_offset <= stream_offset + OFFSET_BITS'(1);
                end else begin
                  cur_byte <= byte_value;
                  res_cnt  <= '0;
                  state    <= ST_CHECK;
                end
              end
              REQ_CLEAR: begin
                record_count  <= '0;
                insert_fill   <= '0;
                next_record   <= '0;
                stream_offset <= '0;
                skip_left     <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_CHECK: begin
          if (rec_match) begin
            next_record <= next_record_inc;
            if (rec_rdata.is_insert) begin
              if (rec_rdata.len != '0) begin
                ins_addr <= rec_rdata.start;
                ins_left <= rec_rdata.len;
                state    <= ST_INS;
              end
            end else if (rec_rdata.len != '0) begin
              skip_left     <= rec_rdata.len - LEN_BITS'(1);
              stream_offset <= stream_offset + OFFSET_BITS'(1);
              state         <= ST_FIN;
            end
          end else if (!gen_block) begin
            stream_offset <= stream_offset + OFFSET_BITS'(1);
            state         <= ST_FIN;
          end
        end
        ST_INS: begin
          if (!gen_block) begin
            ins_left <= ins_left - LEN_BITS'(1);
            ins_addr <= ins_addr + INS_AW'(1);
            if (ins_left == LEN_BITS'(1)) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_FIN: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_byte    <= pend_byte;
            last_of_run <= 1'b1;
            pend_valid  <= 1'b0;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // one result held back so the final one can carry the run flag
      if (gen_fire && res_cnt < RES_CW'(RESULT_LIMIT)) begin
        if (pend_valid) begin
          out_byte    <= pend_byte;
          last_of_run <= 1'b0;
        end
        pend_byte  <= gen_value;
        pend_valid <= 1'b1;
        res_cnt    <= res_cnt + RES_CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    record_count <= REC_CW'(MAX_RECORDS))
    else $error("record count beyond table size");

  a_next_bound: assert property (@(posedge clk) disable iff (rst)
    next_record <= record_count)
    else $error("next record beyond loaded records");

  a_ins_left: assert property (@(posedge clk) disable iff (rst)
    state == ST_INS |-> ins_left != '0)
    else $error("insert run with no bytes left");

  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_CW'(RESULT_LIMIT))
    else $error("result count beyond limit");

endmodule

FILE: src/bspa_ram.sv
// ----------------------------------------------------------------------------
// bspa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: test/patch_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patch_stream_checker
// Watches both channels of the patch applier, keeps its own copy of the
// record table and insert store, works out the patched bytes each accepted
// item should give and compares every output item against them in order.
// ----------------------------------------------------------------------------
module patch_stream_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [1:0]                       req_type,
  input  logic [bspa_pkg::OFFSET_BITS-1:0] rec_offset,
  input  logic                             rec_is_insert,
  input  logic [bspa_pkg::LEN_BITS-1:0]    del_count,
  input  logic [bspa_pkg::BYTE_BITS-1:0]   byte_value,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [bspa_pkg::BYTE_BITS-1:0]   out_byte,
  input  logic                             last_of_run,
  output int                               mismatches,
  output int                               waiting
);
  import bspa_pkg::*;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 last;
  } patched_t;

  patched_t               patched_q[$];
  logic [OFFSET_BITS-1:0] tab_offset [MAX_RECORDS];
  logic                   tab_insert [MAX_RECORDS];
  int                     tab_len    [MAX_RECORDS];
  int                     tab_start  [MAX_RECORDS];
  logic [BYTE_BITS-1:0]   ins_store  [INSERT_STORE];
  int                     n_records;
  int                     fill;
  int                     cursor;
  int                     skip;
  logic [OFFSET_BITS-1:0] stream_pos;

  task automatic flag(input string what);
    if (mismatches < 10) $display("%0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic apply_item(input logic [1:0] req, input logic [OFFSET_BITS-1:0] off,
                            input logic ins, input logic [LEN_BITS-1:0] dc,
                            input logic [BYTE_BITS-1:0] bv);
    logic [BYTE_BITS-1:0] run[$];
    int                   r;
    int                   k;
    bit                   dropped;
    case (req)
      REQ_LOAD_REC: begin
        if (n_records < MAX_RECORDS) begin
          tab_offset[n_records] = off;
          tab_insert[n_records] = ins;
          tab_len[n_records]    = ins ? 0 : int'(dc);
          tab_start[n_records]  = fill;
          n_records++;
        end
      end
      REQ_LOAD_BYTE: begin
        if (n_records > 0) begin
          r = n_records - 1;
          if (tab_insert[r] && tab_len[r] < MAX_INSERT && fill < INSERT_STORE) begin
            ins_store[fill] = bv;
            fill++;
            tab_len[r]++;
          end
        end
      end
      REQ_CLEAR: begin
        n_records  = 0;
        fill       = 0;
        cursor     = 0;
        skip       = 0;
        stream_pos = '0;
      end
      REQ_STREAM: begin
        if (skip > 0) begin
          skip--;
        end else begin
          dropped = 0;
          while (!dropped && cursor < n_records && tab_offset[cursor] == stream_pos) begin
            r = cursor;
            cursor++;
            if (tab_insert[r]) begin
              for (k = 0; k < tab_len[r]; k++)
                if (tab_start[r] + k < INSERT_STORE && run.size() < RESULT_LIMIT)
                  run.push_back(ins_store[tab_start[r] + k]);
            end else if (tab_len[r] > 0) begin
              skip    = tab_len[r] - 1;
              dropped = 1;
            end
          end
          if (!dropped && run.size() < RESULT_LIMIT) run.push_back(bv);
        end
        stream_pos = stream_pos + 1'b1;
        for (k = 0; k < run.size(); k++)
          patched_q.push_back({run[k], k == run.size() - 1});
      end
    endcase
  endtask

  always @(posedge clk) begin
    patched_t exp_item;
    if (rst) begin
      patched_q.delete();
      n_records  = 0;
      fill       = 0;
      cursor     = 0;
      skip       = 0;
      stream_pos = '0;
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (patched_q.size() == 0) begin
          flag($sformatf("unexpected output byte %02h last %0b", out_byte, last_of_run));
        end else begin
          exp_item = patched_q.pop_front();
          if (exp_item.data !== out_byte || exp_item.last !== last_of_run)
            flag($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                           exp_item.data, exp_item.last, out_byte, last_of_run));
        end
      end
      if (in_valid && in_ready)
        apply_item(req_type, rec_offset, rec_is_insert, del_count, byte_value);
    end
    waiting = patched_q.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives record loads, insert bytes, clears and stream bytes into the patch
// applier with random gaps and output stalls; the checker beside the block
// predicts the patched stream and the verdict comes from its failure and waiting counts.
// ----------------------------------------------------------------------------
module testbench;
  import bspa_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   in_valid      = 1'b0;
  logic                   in_ready;
  logic [1:0]             req_type      = REQ_CLEAR;
  logic [OFFSET_BITS-1:0] rec_offset    = '0;
  logic                   rec_is_insert = 1'b0;
  logic [LEN_BITS-1:0]    del_count     = '0;
  logic [BYTE_BITS-1:0]   byte_value    = '0;
  logic                   out_valid;
  logic                   out_ready     = 1'b0;
  logic [BYTE_BITS-1:0]   out_byte;
  logic                   last_of_run;

  int mismatches;
  int waiting;
  int idle_cycles = 0;
  int sent        = 0;
  int pos         = 0;
  bit calm        = 0;

  always #2 clk = ~clk;

  byte_stream_patch_applier dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .rec_offset    (rec_offset),
    .rec_is_insert (rec_is_insert),
    .del_count     (del_count),
    .byte_value    (byte_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run)
  );

  patch_stream_checker stream_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .rec_offset    (rec_offset),
    .rec_is_insert (rec_is_insert),
    .del_count     (del_count),
    .byte_value    (byte_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .mismatches    (mismatches),
    .waiting       (waiting)
  );

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // entered and left just after a falling edge
  task automatic push_item(input logic [1:0] req, input logic [OFFSET_BITS-1:0] off,
                           input logic ins, input logic [LEN_BITS-1:0] dc,
                           input logic [BYTE_BITS-1:0] bv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= req;
    rec_offset    <= off;
    rec_is_insert <= ins;
    del_count     <= dc;
    byte_value    <= bv;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
    if (req == REQ_STREAM) pos++;
    if (req == REQ_CLEAR) pos = 0;
  endtask

  task automatic put_record(input logic [OFFSET_BITS-1:0] off, input logic ins,
                            input logic [LEN_BITS-1:0] dc);
    push_item(REQ_LOAD_REC, off, ins, dc, 8'($urandom));
  endtask

  task automatic put_byte(input logic [1:0] req, input logic [BYTE_BITS-1:0] bv);
    push_item(req, $urandom, 1'($urandom_range(0, 1)), 8'($urandom), bv);
  endtask

  task automatic put_clear();
    put_byte(REQ_CLEAR, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  // ordered records with their bytes, then enough stream bytes to pass them all
  task automatic patch_run();
    int at;
    int n_bytes;
    int dc;
    if ($urandom_range(0, 3) != 0) put_clear();
    at = pos + $urandom_range(0, 3);
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 2) != 0) begin
        put_record(OFFSET_BITS'(at), 1'b1, 8'($urandom));
        n_bytes = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 4);
        repeat (n_bytes) put_byte(REQ_LOAD_BYTE, 8'($urandom));
        at += $urandom_range(0, 2);
      end else begin
        dc = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 4);
        put_record(OFFSET_BITS'(at), 1'b0, 8'(dc));
        at += ($urandom_range(0, 4) == 0) ? $urandom_range(0, dc) : dc + $urandom_range(0, 2);
      end
    end
    repeat (at - pos + $urandom_range(1, 4)) put_byte(REQ_STREAM, 8'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
  end

  initial begin
    int target;
    int r;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    put_byte(REQ_STREAM, 8'hFF);
    put_byte(REQ_LOAD_BYTE, 8'h5A);
    put_record(32'hFFFF_FFFF, 1'b0, 8'd255);
    put_clear();
    put_record(32'd0, 1'b1, 8'd0);
    put_byte(REQ_LOAD_BYTE, 8'h00);
    put_byte(REQ_LOAD_BYTE, 8'hFF);
    put_record(32'd0, 1'b1, 8'd255);
    put_record(32'd1, 1'b0, 8'd0);
    put_record(32'd1, 1'b0, 8'd2);
    put_byte(REQ_LOAD_BYTE, 8'hC3);
    put_record(32'd2, 1'b1, 8'd0);
    put_byte(REQ_LOAD_BYTE, 8'h11);
    put_record(32'd5, 1'b1, 8'd0);
    put_byte(REQ_LOAD_BYTE, 8'h22);
    repeat (7) put_byte(REQ_STREAM, 8'($urandom));
    drain();

    // table full
    put_clear();
    repeat (MAX_RECORDS + 2)
      put_record(OFFSET_BITS'($urandom_range(0, 20)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 3)));
    repeat (24) put_byte(REQ_STREAM, 8'($urandom));

    // two inserts at one byte, more than the output limit
    put_clear();
    put_record(32'd0, 1'b1, 8'($urandom));
    repeat (33) put_byte(REQ_LOAD_BYTE, 8'($urandom));
    put_record(32'd0, 1'b1, 8'($urandom));
    repeat (32) put_byte(REQ_LOAD_BYTE, 8'($urandom));
    repeat (2) put_byte(REQ_STREAM, 8'($urandom));
    drain();

    target = 380;
    while (sent < target) begin
      calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        patch_run();
      end else begin
        repeat ($urandom_range(3, 10))
          push_item(2'($urandom), $urandom, 1'($urandom_range(0, 1)), 8'($urandom),
                    8'($urandom));
      end
      if ($urandom_range(0, 4) == 0) drain();
    end

    in_valid <= 1'b0;
    calm = 0;
    while (waiting != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (mismatches == 0 && waiting == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: byte_stream_patch_applier.f
src/bspa_pkg.sv
src/bspa_ram.sv
src/byte_stream_patch_applier.sv
test/patch_stream_checker.sv
test/testbench.sv
